// ===== rtl/sbh_pkg.sv =====
// Shared types, constants and helpers for the seeded 64-bit byte hash.
`default_nettype none

package sbh_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int COUNT_W = 4;
    localparam int LEN_W   = 32;
    localparam int TDATA_W = 104;

    localparam logic [WORD_W-1:0] GOLDEN_MUL = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hFF51AFD7ED558CCD;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'hC4CEB9FE1A85EC53;
    localparam logic [WORD_W-1:0] FNV_PRIME  = 64'h00000100000001B3;
    localparam logic [WORD_W-1:0] SEED_RESET = 64'h000000001234ABCD;
    localparam int                MIX_SHIFT  = 33;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SEED,
        S_ABSORB,
        S_WMUL_A,
        S_WMUL_B,
        S_AMUL,
        S_BYTE,
        S_TAIL,
        S_FIN,
        S_OUT
    } sbh_state_t;

    // Partial-product phases of the shared multiplier
    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LL,
        MP_HL,
        MP_LH
    } sbh_mul_phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sbh_mul_stat_t;

    function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sbh_mul64.sv =====
// Low 64 bits of a 64x64 product from one 32x32 multiplier, summing the LL, HL and LH partial products.
`default_nettype none

module sbh_mul64 import sbh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] op_a,
    input  wire logic [WORD_W-1:0] op_b,
    output logic      [WORD_W-1:0] product,
    output sbh_mul_stat_t          stat
);

    sbh_mul_phase_t    phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] a_reg, b_reg;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [HALF_W-1:0] mx, my;
    logic [WORD_W-1:0] pp;

    always_comb
    begin
        case (phase_reg)
            MP_LL:
            begin
                mx = a_reg[HALF_W-1:0];
                my = b_reg[HALF_W-1:0];
            end
            MP_HL:
            begin
                mx = a_reg[WORD_W-1:HALF_W];
                my = b_reg[HALF_W-1:0];
            end
            MP_LH:
            begin
                mx = a_reg[HALF_W-1:0];
                my = b_reg[WORD_W-1:HALF_W];
            end
            default:
            begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    assign pp = WORD_W'(mx) * WORD_W'(my);

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        case (phase_reg)
            MP_IDLE:
            begin
                if (start)
                begin
                    phase_next = MP_LL;
                end
            end
            MP_LL:
            begin
                prod_next  = pp;
                phase_next = MP_HL;
            end
            MP_HL:
            begin
                // cross terms only reach the upper half
                prod_next  = {prod_reg[WORD_W-1:HALF_W] + pp[HALF_W-1:0],
                              prod_reg[HALF_W-1:0]};
                phase_next = MP_LH;
            end
            MP_LH:
            begin
                prod_next  = {prod_reg[WORD_W-1:HALF_W] + pp[HALF_W-1:0],
                              prod_reg[HALF_W-1:0]};
                phase_next = MP_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                phase_next = MP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (start && phase_reg == MP_IDLE)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
    end

    assign product   = prod_reg;
    assign stat.busy = (phase_reg != MP_IDLE);
    assign stat.done = done_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held for more than one cycle");

endmodule

`default_nettype wire

// ===== rtl/seeded_64bit_byte_hash.sv =====
// Seeded 64-bit byte hash: one item is taken while idle and worked through the shared multiplier.
// Each 64-bit multiply runs three partial products through the 32x32 multiplier, then returns the result.
// An input beat takes one multiply for the seed if first, three for a full word or n for an n-byte
// tail, and one more if last; the next beat is taken only once the current item is through.
// Reset clears the running hash to zero, the seed to 0x1234ABCD and the output valid.
`default_nettype none

module seeded_64bit_byte_hash import sbh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               seed_we,
    input  wire logic [WORD_W-1:0]  seed_wdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // data_word [63:0], byte_count [67:64], total_length [99:68], zero pad [103:100]
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    // first [0]
    input  wire logic               s_axis_tuser,
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // hash [63:0]
    output logic [WORD_W-1:0]       m_axis_tdata
);

    sbh_state_t        state_reg, state_next;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [2:0]        count_reg, count_next;
    logic              full_reg, full_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              first_reg, first_next;
    logic              last_reg, last_next;
    logic [WORD_W-1:0] hash_reg, hash_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_load;

    logic              mul_start;
    logic [WORD_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] mul_prod;
    sbh_mul_stat_t     mul_stat;

    logic              in_beat;
    logic [WORD_W-1:0] acc_byte;

    sbh_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign acc_byte = acc_reg ^ {{(WORD_W-8){1'b0}}, w_reg[7:0]};
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_beat) state_next = S_LOAD;
            S_LOAD:   state_next = first_reg ? S_SEED : S_ABSORB;
            S_SEED:   if (mul_stat.done) state_next = S_ABSORB;
            S_ABSORB:
            begin
                if (full_reg)
                    state_next = S_WMUL_A;
                else if (count_reg != 3'd0)
                    state_next = S_BYTE;
                else
                    state_next = S_TAIL;
            end
            S_WMUL_A: if (mul_stat.done) state_next = S_WMUL_B;
            S_WMUL_B: if (mul_stat.done) state_next = S_AMUL;
            S_AMUL:   if (mul_stat.done) state_next = S_TAIL;
            S_BYTE:   if (mul_stat.done) state_next = S_ABSORB;
            S_TAIL:   state_next = last_reg ? S_FIN : S_IDLE;
            S_FIN:    if (mul_stat.done) state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        mul_start     = 1'b0;
        mul_a         = w_reg;
        mul_b         = MIX_MUL_A;
        acc_next      = acc_reg;
        w_next        = w_reg;
        count_next    = count_reg;
        full_next     = full_reg;
        len_next      = len_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        hash_next     = hash_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    w_next     = s_axis_tdata[63:0];
                    // counts of eight and above mix the whole word
                    full_next  = s_axis_tdata[67];
                    count_next = s_axis_tdata[66:64];
                    len_next   = s_axis_tdata[99:68];
                    first_next = s_axis_tuser;
                    last_next  = s_axis_tlast;
                end
            end
            S_LOAD:
            begin
                if (first_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = {{(WORD_W-LEN_W){1'b0}}, len_reg};
                    mul_b     = GOLDEN_MUL;
                end
            end
            S_SEED:
            begin
                if (mul_stat.done)
                    acc_next = seed_reg ^ mul_prod;
            end
            S_ABSORB:
            begin
                if (full_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = w_reg;
                    mul_b     = MIX_MUL_A;
                end
                else if (count_reg != 3'd0)
                begin
                    acc_next  = acc_byte;
                    mul_start = 1'b1;
                    mul_a     = acc_byte;
                    mul_b     = FNV_PRIME;
                end
            end
            S_WMUL_A:
            begin
                if (mul_stat.done)
                begin
                    mul_start = 1'b1;
                    mul_a     = xor_shift(mul_prod);
                    mul_b     = MIX_MUL_B;
                end
            end
            S_WMUL_B:
            begin
                if (mul_stat.done)
                begin
                    acc_next  = acc_reg ^ mul_prod;
                    mul_start = 1'b1;
                    mul_a     = acc_reg ^ mul_prod;
                    mul_b     = MIX_MUL_A;
                end
            end
            S_AMUL:
            begin
                if (mul_stat.done)
                    acc_next = xor_shift(mul_prod);
            end
            S_BYTE:
            begin
                if (mul_stat.done)
                begin
                    // advance to the next byte of the tail
                    acc_next   = mul_prod;
                    w_next     = w_reg >> 8;
                    count_next = count_reg - 3'd1;
                end
            end
            S_TAIL:
            begin
                if (last_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = xor_shift(acc_reg);
                    mul_b     = MIX_MUL_A;
                end
            end
            S_OUT:
            begin
                if (out_load)
                    hash_next = xor_shift(mul_prod);
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !m_axis_tready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= SEED_RESET;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            full_reg      <= 1'b0;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            full_reg      <= full_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            if (seed_we)
                seed_reg <= seed_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        len_reg  <= len_next;
        hash_reg <= hash_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = hash_reg;

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("input taken again while an item is in work");

    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == S_SEED || state_reg == S_WMUL_A ||
                           state_reg == S_WMUL_B || state_reg == S_AMUL ||
                           state_reg == S_BYTE || state_reg == S_FIN))
        else $error("multiplier result arrived with no step waiting for it");

    a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(last_reg))
        else $error("result produced for an item not marked last");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the seeded 64-bit byte hash streaming block.
`timescale 1ns / 100ps

module tb;

    import sbh_pkg::*;

    localparam logic [63:0] GOLDEN_K   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] AVAL_MUL_A = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] AVAL_MUL_B = 64'hC4CEB9FE1A85EC53;
    localparam logic [63:0] FNV_K      = 64'h00000100000001B3;
    localparam logic [63:0] SEED_RST   = 64'h000000001234ABCD;
    localparam int          SHIFT_K    = 33;
    localparam int          SETTLE_CYC = 60;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 96;
    localparam int          N_PHASES    = 5;
    localparam int          HOLD_AT     = 25;
    localparam int          HOLD_CYC    = 300;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic [31:0] total_length;
        logic        is_first;
        logic        is_last;
    } hash_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               seed_we = 1'b0;
    logic [WORD_W-1:0]  seed_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [WORD_W-1:0]  m_axis_tdata;

    hash_item_t  pending_q[$];
    logic [63:0] hash_q[$];
    hash_item_t  offer_item = '0;
    logic [63:0] run_hash = '0;
    logic [63:0] seed_now = SEED_RST;
    logic [63:0] phase_seeds [N_PHASES];
    bit          gaps_on = 1'b1;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          hashes_seen = 0;
    int          errors = 0;
    int unsigned queued = 0;

    seeded_64bit_byte_hash i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_we       (seed_we),
        .seed_wdata    (seed_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] mix_word(input logic [63:0] acc, input logic [63:0] w);
        w   = w * AVAL_MUL_A;
        w   = w ^ (w >> SHIFT_K);
        w   = w * AVAL_MUL_B;
        acc = acc ^ w;
        acc = acc * AVAL_MUL_A;
        return acc ^ (acc >> SHIFT_K);
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] v);
        v = v ^ (v >> SHIFT_K);
        v = v * AVAL_MUL_A;
        return v ^ (v >> SHIFT_K);
    endfunction

    // Fold one accepted beat into the running hash; a last beat yields a finished hash
    task automatic absorb_item(input hash_item_t it);
        logic [63:0] acc;
        acc = run_hash;
        if (it.is_first)
            acc = seed_now ^ ({32'b0, it.total_length} * GOLDEN_K);
        if (it.byte_count >= 4'd8)
            acc = mix_word(acc, it.data_word);
        else
            for (int i = 0; i < int'(it.byte_count); i++)
                acc = (acc ^ {56'b0, it.data_word[8*i +: 8]}) * FNV_K;
        run_hash = acc;
        if (it.is_last)
            hash_q.push_back(avalanche(acc));
    endtask

    task automatic queue_item(input logic [63:0] w, input logic [3:0] cnt,
                              input logic [31:0] len, input logic f, input logic l);
        hash_item_t it;
        it.data_word    = w;
        it.byte_count   = cnt;
        it.total_length = len;
        it.is_first     = f;
        it.is_last      = l;
        pending_q.push_back(it);
        queued++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Queue one well-formed message: full words, an optional short tail, maybe an empty last beat
    task automatic queue_message();
        int unsigned n_full;
        int unsigned tail;
        int unsigned n_beats;
        logic [31:0] len;
        logic [3:0]  cnt;
        bit          extra_end;
        n_full    = $urandom_range(0, 4);
        tail      = $urandom_range(0, 7);
        extra_end = ($urandom_range(0, 5) == 0);
        n_beats   = n_full + ((tail != 0) ? 1 : 0);
        if (n_beats == 0)
            n_beats = 1;
        if (extra_end)
            n_beats++;
        len = ($urandom_range(0, 7) == 0) ? $urandom : 32'(n_full * 8 + tail);
        for (int unsigned k = 0; k < n_beats; k++)
        begin
            if (k < n_full)
                cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
            else if (k == n_full)
                cnt = 4'(tail);
            else
                cnt = 4'd0;
            queue_item(rand64(), cnt, (k == 0) ? len : $urandom, k == 0, k == n_beats - 1);
        end
    endtask

    // Hold until the block has drained, then allow for a beat that produces no hash
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || hash_q.size() != 0);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        @(posedge clk);
        seed_we    <= 1'b1;
        seed_wdata <= v;
        seed_now    = v;
        @(posedge clk);
        seed_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Driver: advance to the next queued beat once the current one is taken
    always @(posedge clk)
    begin
        logic offer;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_item(offer_item);
                offer = 1'b0;
            end
            if (!offer && pending_q.size() != 0)
            begin
                if (send_gap == 0 && gaps_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 9);
                if (send_gap != 0)
                    send_gap--;
                else
                begin
                    offer_item = pending_q.pop_front();
                    offer      = 1'b1;
                end
            end
            s_axis_tvalid <= offer;
            s_axis_tdata  <= {4'b0, offer_item.total_length, offer_item.byte_count,
                              offer_item.data_word};
            s_axis_tuser  <= offer_item.is_first;
            s_axis_tlast  <= offer_item.is_last;
        end
    end

    // Monitor: check each hash beat and throttle tready
    always @(posedge clk)
    begin
        logic [63:0] want;
        logic        rdy;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (hash_q.size() == 0)
                begin
                    $display("%0t: hash beat with none expected, expected none, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = hash_q.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: hash mismatch, expected %h, got %h",
                                 $time, want, m_axis_tdata);
                        errors++;
                    end
                end
                hashes_seen++;
                // Back-pressure long enough for the input side to stall
                if (hashes_seen == HOLD_AT)
                    hold_left = HOLD_CYC;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    initial
    begin
        for (int n = 0; n < CYCLE_LIMIT; n++)
            @(posedge clk);
        $display("seeded_64bit_byte_hash: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned phase_end;
        phase_seeds[0] = 64'h0;
        phase_seeds[1] = 64'hFFFFFFFFFFFFFFFF;
        phase_seeds[2] = rand64();
        phase_seeds[3] = 64'h8000000000000001;
        phase_seeds[4] = rand64();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset seed, running hash still zero
        queue_item(64'h0123456789ABCDEF, 4'd8, 32'd0, 1'b0, 1'b1);
        queue_item(64'h0, 4'd0, 32'd0, 1'b1, 1'b1);
        queue_item(64'hFFFFFFFFFFFFFFFF, 4'd8, 32'hFFFFFFFF, 1'b1, 1'b1);
        queue_item(64'h0, 4'd8, 32'd0, 1'b1, 1'b1);
        for (int c = 1; c < 8; c++)
            queue_item(rand64(), 4'(c), 32'(c), 1'b1, 1'b1);
        // Short beat, then a full word mixed regardless, then an empty last beat
        queue_item(rand64(), 4'd3, 32'd19, 1'b1, 1'b0);
        queue_item(rand64(), 4'd8, $urandom, 1'b0, 1'b0);
        queue_item(rand64(), 4'd0, 32'd0, 1'b0, 1'b1);
        // Carry on from the pre-avalanche value with no new first beat
        queue_item(rand64(), 4'd5, 32'd0, 1'b0, 1'b1);
        // Oversized byte counts mix the full word
        queue_item(rand64(), 4'd9, 32'd9, 1'b1, 1'b1);
        queue_item(rand64(), 4'd12, 32'd12, 1'b1, 1'b1);
        queue_item(rand64(), 4'd15, 32'hFFFFFFFF, 1'b1, 1'b1);
        queue_item(rand64(), 4'd8, 32'd23, 1'b1, 1'b0);
        queue_item(rand64(), 4'd8, 32'd0, 1'b0, 1'b0);
        queue_item(64'hFFFFFFFFFFFFFFFF, 4'd7, 32'd0, 1'b0, 1'b1);
        queue_item(rand64(), 4'd0, 32'd0, 1'b0, 1'b0);
        queue_item(rand64(), 4'd2, 32'd0, 1'b0, 1'b1);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_seed(phase_seeds[p]);
            gaps_on   = (p != N_PHASES - 1);
            phase_end = queued + PHASE_ITEMS;
            while (queued < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_item(rand64(), 4'($urandom_range(0, 15)), $urandom,
                               1'($urandom), 1'($urandom));
                else
                    queue_message();
            end
            wait_idle();
        end

        if (errors == 0)
            $display("seeded_64bit_byte_hash: match");
        else
            $display("seeded_64bit_byte_hash: mismatch");
        $finish;
    end

endmodule
